>>> sv/link_reconnect_backoff_fsm_macros.svh
// ----------------------------------------------------------------------------
// Link reconnect backoff FSM assertion macros
// Shared assertion shorthands for the checker of the link manager.
// ----------------------------------------------------------------------------
`ifndef LINK_RECONNECT_BACKOFF_FSM_MACROS_SVH
`define LINK_RECONNECT_BACKOFF_FSM_MACROS_SVH

// Concurrent assertion on clk, disabled while rst is high.
`define LRB_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion on a result transaction that matches a condition.
`define LRB_ASSERT_OUT(label, cond, prop, msg) \
  `LRB_ASSERT_CLK(label, (m_tvalid && (cond)) |-> (prop), msg)

`endif

>>> sv/lrb_pkg.sv
// ----------------------------------------------------------------------------
// Link reconnect backoff package
// Widths, codes and shared types of the link connection manager.
// ----------------------------------------------------------------------------
package lrb_pkg;

  localparam int TIME_W     = 32;
  localparam int FAIL_W     = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 56;

  // Link state codes as seen on the result stream.
  localparam logic [2:0] LS_INIT         = 3'd0;
  localparam logic [2:0] LS_CONNECTING   = 3'd1;
  localparam logic [2:0] LS_CONNECTED    = 3'd2;
  localparam logic [2:0] LS_FAILED       = 3'd3;
  localparam logic [2:0] LS_PORTAL       = 3'd4;
  localparam logic [2:0] LS_RECONNECTING = 3'd5;

  // Event codes carried in tuser.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_START   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BACKOFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFF     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_MODE    = 2'd3;

  localparam logic [TIME_W-1:0] CONNECT_TIMEOUT_RST = 32'd15000;
  localparam logic [TIME_W-1:0] INITIAL_BACKOFF_RST = 32'd1000;
  localparam logic [TIME_W-1:0] MAX_BACKOFF_RST     = 32'd300000;

  // Timing and counter results handed from the arithmetic unit to the FSM.
  typedef struct packed {
    logic              timeout_hit;
    logic              backoff_done;
    logic              deadline_passed;
    logic [TIME_W-1:0] request_deadline;
    logic [TIME_W-1:0] start_deadline;
    logic [TIME_W-1:0] backoff_doubled;
    logic [FAIL_W-1:0] failures_inc;
  } arith_t;

endpackage

>>> sv/lrb_arith.sv
// ----------------------------------------------------------------------------
// Link reconnect arithmetic
// Wrapping time compares, deadline sums, backoff doubling and failure count.
// ----------------------------------------------------------------------------
module lrb_arith (
  input  logic [lrb_pkg::TIME_W-1:0] now_ms,
  input  logic [lrb_pkg::TIME_W-1:0] keep_alive_ms,
  input  logic [lrb_pkg::TIME_W-1:0] attempt_start_ms,
  input  logic [lrb_pkg::TIME_W-1:0] last_attempt_ms,
  input  logic [lrb_pkg::TIME_W-1:0] backoff_ms,
  input  logic [lrb_pkg::TIME_W-1:0] request_deadline_ms,
  input  logic [lrb_pkg::TIME_W-1:0] connect_timeout_ms,
  input  logic [lrb_pkg::TIME_W-1:0] max_backoff_ms,
  input  logic [lrb_pkg::FAIL_W-1:0] failures,
  output lrb_pkg::arith_t            arith
);

  logic [lrb_pkg::TIME_W-1:0] since_attempt;
  logic [lrb_pkg::TIME_W-1:0] since_last;
  logic [lrb_pkg::TIME_W-1:0] until_ms;

  // Differences and sums wrap at the time width.
  assign since_attempt = now_ms - attempt_start_ms;
  assign since_last    = now_ms - last_attempt_ms;
  assign until_ms      = now_ms + keep_alive_ms;

  always_comb begin
    arith.timeout_hit      = (since_attempt >= connect_timeout_ms);
    arith.backoff_done     = (since_last >= backoff_ms);
    // The deadline is compared as a plain unsigned value.
    arith.deadline_passed  = !(request_deadline_ms > now_ms);
    arith.request_deadline = (until_ms > request_deadline_ms) ? until_ms : request_deadline_ms;
    arith.start_deadline   = now_ms + connect_timeout_ms;
    arith.backoff_doubled  = (backoff_ms > (max_backoff_ms >> 1)) ?
                             max_backoff_ms : {backoff_ms[lrb_pkg::TIME_W-2:0], 1'b0};
    arith.failures_inc     = (&failures) ? failures : failures + 1'b1;
  end

endmodule

>>> sv/link_reconnect_backoff_fsm.sv
// An accepted event goes to the input register; the state and result registers
// load it from there once the result register is empty or being drained.
// Throughput: one event per cycle while results are not stalled; the whole
// state update is a single compare-and-update step between the two registers.
// Reset: synchronous, active high; clears the FSM to init, zeroes the timers
// and counters, loads the configuration defaults and empties both stages.
// ----------------------------------------------------------------------------
// Link reconnect backoff FSM
// Link connection manager with timed attempts and exponential retry backoff.
// ----------------------------------------------------------------------------
module link_reconnect_backoff_fsm (
  input  logic                              clk,
  input  logic                              rst,
  // Event stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: now_ms[31:0], keep_alive_ms[63:32], link_up[64], credentials_saved[65],
  //          provisioning_mode[66], portal_still_running[67], zero fill[71:68]
  input  logic [lrb_pkg::IN_DATA_W-1:0]     s_tdata,
  // s_tuser: operation[1:0]
  input  logic [1:0]                        s_tuser,
  // Result stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: link_state[2:0], state_changed[3], connect_cmd[4], disconnect_cmd[5],
  //          portal_cmd[6], failure_total[22:7], retry_wait_ms[54:23], zero fill[55]
  output logic [lrb_pkg::OUT_DATA_W-1:0]    m_tdata,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [lrb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrb_pkg::CFG_W-1:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_INIT         = lrb_pkg::LS_INIT,
    S_CONNECTING   = lrb_pkg::LS_CONNECTING,
    S_CONNECTED    = lrb_pkg::LS_CONNECTED,
    S_FAILED       = lrb_pkg::LS_FAILED,
    S_PORTAL       = lrb_pkg::LS_PORTAL,
    S_RECONNECTING = lrb_pkg::LS_RECONNECTING
  } state_t;

  // Configuration.
  logic [lrb_pkg::TIME_W-1:0] connect_timeout;
  logic [lrb_pkg::TIME_W-1:0] initial_backoff;
  logic [lrb_pkg::TIME_W-1:0] max_backoff;
  logic                       battery_mode;

  // Input stage.
  logic                       in_valid;
  logic [1:0]                 in_op;
  logic [lrb_pkg::TIME_W-1:0] in_now;
  logic [lrb_pkg::TIME_W-1:0] in_keep;
  logic                       in_up;
  logic                       in_creds;
  logic                       in_prov;
  logic                       in_portal_run;

  // Manager state.
  state_t                     fsm;
  logic                       started;
  logic                       portal_on;
  logic [lrb_pkg::TIME_W-1:0] attempt_start;
  logic [lrb_pkg::TIME_W-1:0] last_attempt;
  logic [lrb_pkg::TIME_W-1:0] backoff;
  logic [lrb_pkg::FAIL_W-1:0] failures;
  logic [lrb_pkg::TIME_W-1:0] deadline;

  state_t                     fsm_next;
  logic                       started_next;
  logic                       portal_on_next;
  logic [lrb_pkg::TIME_W-1:0] attempt_start_next;
  logic [lrb_pkg::TIME_W-1:0] last_attempt_next;
  logic [lrb_pkg::TIME_W-1:0] backoff_next;
  logic [lrb_pkg::FAIL_W-1:0] failures_next;
  logic [lrb_pkg::TIME_W-1:0] deadline_next;

  // Output stage.
  logic                       out_valid;
  logic [lrb_pkg::OUT_DATA_W-1:0] out_data;
  logic [lrb_pkg::OUT_DATA_W-1:0] out_data_next;

  // Event decode.
  logic base_portal;
  logic start_ev;
  logic do_launch;
  logic again;
  logic do_portal;
  logic do_link;
  logic do_fail;
  logic fail_disc;
  logic do_failed_only;
  logic link_drop;
  logic changed;
  logic connect_cmd;
  logic disconnect_cmd;
  logic portal_cmd;
  logic fire;

  lrb_pkg::arith_t arith;

  lrb_arith u_arith (
    .now_ms              (in_now),
    .keep_alive_ms       (in_keep),
    .attempt_start_ms    (attempt_start),
    .last_attempt_ms     (last_attempt),
    .backoff_ms          (backoff),
    .request_deadline_ms (deadline),
    .connect_timeout_ms  (connect_timeout),
    .max_backoff_ms      (max_backoff),
    .failures            (failures),
    .arith               (arith)
  );

  // The held event moves on when the result register is empty or being drained.
  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    fsm_next           = fsm;
    started_next       = started;
    portal_on_next     = portal_on;
    attempt_start_next = attempt_start;
    last_attempt_next  = last_attempt;
    backoff_next       = backoff;
    failures_next      = failures;
    deadline_next      = deadline;
    base_portal        = portal_on;
    start_ev           = 1'b0;
    do_launch          = 1'b0;
    again              = 1'b0;
    do_portal          = 1'b0;
    do_link            = 1'b0;
    do_fail            = 1'b0;
    fail_disc          = 1'b0;
    do_failed_only     = 1'b0;
    link_drop          = 1'b0;
    connect_cmd        = 1'b0;
    disconnect_cmd     = 1'b0;
    portal_cmd         = 1'b0;

    case (in_op)
      lrb_pkg::OP_TICK: begin
        if (started) begin
          if (portal_on) begin
            // The portal closed on its own: resume from the link status.
            if (!in_portal_run) begin
              portal_on_next = 1'b0;
              if (in_up) begin
                do_link = 1'b1;
              end else if (in_creds) begin
                do_launch = 1'b1;
                again     = 1'b1;
              end else begin
                do_failed_only = 1'b1;
              end
            end
          end else if (in_up) begin
            do_link = 1'b1;
          end else begin
            case (fsm)
              S_INIT: begin
                if (in_prov) begin
                  do_portal = 1'b1;
                end else if (in_creds) begin
                  do_launch = 1'b1;
                end else begin
                  do_failed_only = 1'b1;
                end
              end
              S_CONNECTING, S_RECONNECTING: begin
                if (arith.timeout_hit) begin
                  do_fail   = 1'b1;
                  fail_disc = 1'b1;
                end
              end
              S_FAILED: begin
                if (arith.backoff_done) begin
                  if (in_prov) begin
                    do_portal = 1'b1;
                  end else if (in_creds) begin
                    do_launch = 1'b1;
                    again     = 1'b1;
                  end
                end
              end
              default: begin
                // A link lost while connected or in the portal state.
                if (in_prov) begin
                  do_portal = 1'b1;
                end else begin
                  do_fail = 1'b1;
                end
              end
            endcase
          end
        end
      end
      lrb_pkg::OP_REQUEST: begin
        deadline_next = arith.request_deadline;
        if (fsm == S_INIT && in_creds) begin
          do_launch = 1'b1;
        end else if (fsm == S_FAILED && in_creds && arith.backoff_done) begin
          do_launch = 1'b1;
          again     = 1'b1;
        end
      end
      lrb_pkg::OP_RELEASE: begin
        deadline_next = '0;
      end
      default: begin
        started_next       = 1'b1;
        portal_on_next     = 1'b0;
        base_portal        = 1'b0;
        start_ev           = 1'b1;
        attempt_start_next = '0;
        last_attempt_next  = '0;
        backoff_next       = initial_backoff;
        failures_next      = '0;
        deadline_next      = arith.start_deadline;
        fsm_next           = S_INIT;
        if (in_prov) begin
          do_portal = 1'b1;
        end else if (in_creds) begin
          do_launch = 1'b1;
        end else begin
          do_failed_only = 1'b1;
        end
      end
    endcase

    if (do_launch) begin
      connect_cmd        = 1'b1;
      attempt_start_next = in_now;
      last_attempt_next  = in_now;
      fsm_next           = again ? S_RECONNECTING : S_CONNECTING;
    end
    if (do_portal && !base_portal) begin
      disconnect_cmd     = 1'b1;
      portal_cmd         = 1'b1;
      portal_on_next     = 1'b1;
      attempt_start_next = '0;
      fsm_next           = S_PORTAL;
    end
    if (do_link) begin
      attempt_start_next = '0;
      failures_next      = '0;
      backoff_next       = initial_backoff;
      // In battery mode an idle link is dropped right after it connects.
      link_drop          = battery_mode && !portal_on_next && arith.deadline_passed;
      disconnect_cmd     = link_drop;
      fsm_next           = link_drop ? S_INIT : S_CONNECTED;
    end
    if (do_fail) begin
      disconnect_cmd    = fail_disc;
      failures_next     = arith.failures_inc;
      last_attempt_next = in_now;
      backoff_next      = arith.backoff_doubled;
      fsm_next          = S_FAILED;
    end
    if (do_failed_only) begin
      fsm_next = S_FAILED;
    end

    // A start or a connect-then-drop passes through another state on the way.
    changed = start_ev || link_drop || (fsm_next != fsm);

    out_data_next = {1'b0, backoff_next, failures_next, portal_cmd, disconnect_cmd,
                     connect_cmd, changed, fsm_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connect_timeout <= lrb_pkg::CONNECT_TIMEOUT_RST;
      initial_backoff <= lrb_pkg::INITIAL_BACKOFF_RST;
      max_backoff     <= lrb_pkg::MAX_BACKOFF_RST;
      battery_mode    <= 1'b0;
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      fsm             <= S_INIT;
      started         <= 1'b0;
      portal_on       <= 1'b0;
      attempt_start   <= '0;
      last_attempt    <= '0;
      backoff         <= '0;
      failures        <= '0;
      deadline        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lrb_pkg::CFG_CONNECT_TIMEOUT: connect_timeout <= cfg_data;
          lrb_pkg::CFG_INITIAL_BACKOFF: initial_backoff <= cfg_data;
          lrb_pkg::CFG_MAX_BACKOFF:     max_backoff     <= cfg_data;
          lrb_pkg::CFG_BATTERY_MODE:    battery_mode    <= cfg_data[0];
          default:                      battery_mode    <= battery_mode;
        endcase
      end

      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (s_tvalid && s_tready) begin
        in_op         <= s_tuser;
        in_now        <= s_tdata[31:0];
        in_keep       <= s_tdata[63:32];
        in_up         <= s_tdata[64];
        in_creds      <= s_tdata[65];
        in_prov       <= s_tdata[66];
        in_portal_run <= s_tdata[67];
      end

      if (fire) begin
        out_valid     <= 1'b1;
        out_data      <= out_data_next;
        fsm           <= fsm_next;
        started       <= started_next;
        portal_on     <= portal_on_next;
        attempt_start <= attempt_start_next;
        last_attempt  <= last_attempt_next;
        backoff       <= backoff_next;
        failures      <= failures_next;
        deadline      <= deadline_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/lrb_checker.sv
// ----------------------------------------------------------------------------
// Link reconnect checker
// Port-level checks on the result stream of the link connection manager.
// ----------------------------------------------------------------------------
`include "link_reconnect_backoff_fsm_macros.svh"

module lrb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lrb_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic [2:0] link_state;
  logic       connect_cmd;
  logic       disconnect_cmd;
  logic       portal_cmd;
  logic       in_attempt;
  logic       res_stall;

  assign link_state     = m_tdata[2:0];
  assign connect_cmd    = m_tdata[4];
  assign disconnect_cmd = m_tdata[5];
  assign portal_cmd     = m_tdata[6];
  assign in_attempt     = (link_state == lrb_pkg::LS_CONNECTING) ||
                          (link_state == lrb_pkg::LS_RECONNECTING);
  assign res_stall      = m_tvalid && !m_tready;

  `LRB_ASSERT_CLK(a_result_hold, res_stall |=> m_tvalid && $stable(m_tdata), "held result changed")
  `LRB_ASSERT_OUT(a_connect_state, connect_cmd, in_attempt, "connect outside an attempt state")
  `LRB_ASSERT_OUT(a_connect_no_drop, connect_cmd, !disconnect_cmd && !portal_cmd, "connect with drop")
  `LRB_ASSERT_OUT(a_portal_state, portal_cmd, disconnect_cmd && link_state == lrb_pkg::LS_PORTAL, "bad portal")

endmodule

bind link_reconnect_backoff_fsm lrb_checker u_lrb_checker (.*);
